// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the calendar clock modules. Each macro expects
// signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define GCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checks that a condition implies a property, outside of reset.
`define GCC_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> prop) \
    else $error(msg);

`endif

// ===== design/gcc_pkg.sv =====
// ----------------------------------------------------------------------------
// gcc_pkg
// Types, constants and calendar helper functions for the game calendar clock.
// ----------------------------------------------------------------------------
package gcc_pkg;

  // Default number of fraction bits for the time of day.
  localparam int FRACTION_BITS_DEFAULT = 8;

  // Datapath widths.
  localparam int LEN_W       = 26;
  localparam int CD_W        = 27;
  localparam int PERIOD_W    = 10;
  localparam int TIME_W      = 19;
  localparam int HM_W        = 11;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 26;

  // Rollover limits.
  localparam logic [5:0]  MINUTE_LAST      = 6'd59;
  localparam logic [4:0]  HOUR_LAST        = 5'd23;
  localparam logic [3:0]  MONTH_LAST       = 4'd12;
  localparam logic [13:0] YEAR_LAST        = 14'd9999;
  localparam logic [6:0]  MINUTES_PER_HOUR = 7'd60;

  // Divisibility by 25 through the modular inverse of 25 modulo 2^12.
  localparam logic [11:0] INV25      = 12'd3113;
  localparam logic [11:0] MULT25_MAX = 12'd163;

  // Operation codes.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MINUTE_LENGTH  = 3'd0,
    REG_PRECISE_PERIOD = 3'd1,
    REG_START_YEAR     = 3'd2,
    REG_START_MONTH    = 3'd3,
    REG_START_DAY      = 3'd4,
    REG_START_HOUR     = 3'd5,
    REG_START_MINUTE   = 3'd6
  } cfg_reg_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // Input transaction.
  typedef struct packed {
    logic        operation;
    logic [19:0] delta_time_us;
  } in_item_t;

  // Output transaction.
  typedef struct packed {
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [13:0] year;
    logic [8:0]  day_of_year;
    logic [18:0] time_of_day;
    logic        precise_update;
    logic        hour_event;
    logic        day_event;
    logic        month_event;
    logic        year_event;
  } out_item_t;

  // Calendar state.
  typedef struct packed {
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [8:0]  day_of_year;
  } date_t;

  // Calendar update requests.
  typedef struct packed {
    logic load;
    logic advance;
  } cal_ctrl_t;

  // Rollover pulses.
  typedef struct packed {
    logic hour;
    logic day;
    logic month;
    logic year;
  } cal_event_t;

  // True when x is a multiple of 25.
  function automatic logic is_mult25(input logic [11:0] x);
    logic [23:0] prod;
    prod = x * INV25;
    return prod[11:0] <= MULT25_MAX;
  endfunction

  // Gregorian leap rule, with the hundreds tested as multiples of 25 after
  // the low two or four bits are known to be zero.
  function automatic logic is_leap(input logic [13:0] year);
    logic by4;
    logic by16;
    by4  = year[1:0] == 2'b00;
    by16 = by4 && (year[3:2] == 2'b00);
    return by4 && (!is_mult25(year[13:2]) || (by16 && is_mult25({2'b00, year[13:4]})));
  endfunction

  // Days in a month; a month outside 1..12 counts as 31 days.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] days;
    unique case (month)
      4'd2:                   days = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
      default:                days = 5'd31;
    endcase
    return days;
  endfunction

  // Days in the year before the first of a month. Months above 12 count the
  // whole year.
  function automatic logic [8:0] days_before(input logic [3:0] month, input logic leap);
    logic [8:0] base;
    unique case (month)
      4'd0, 4'd1: base = 9'd0;
      4'd2:       base = 9'd31;
      4'd3:       base = 9'd59;
      4'd4:       base = 9'd90;
      4'd5:       base = 9'd120;
      4'd6:       base = 9'd151;
      4'd7:       base = 9'd181;
      4'd8:       base = 9'd212;
      4'd9:       base = 9'd243;
      4'd10:      base = 9'd273;
      4'd11:      base = 9'd304;
      4'd12:      base = 9'd334;
      default:    base = 9'd365;
    endcase
    return base + ((leap && (month >= 4'd3)) ? 9'd1 : 9'd0);
  endfunction

endpackage

// ===== design/gcc_frac_div.sv =====
// ----------------------------------------------------------------------------
// gcc_frac_div
// Bit-serial restoring divider for the fraction of the current minute. It
// produces one quotient bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcc_frac_div #(
  parameter int FRACTION_BITS = gcc_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gcc_pkg::LEN_W-1:0]  numerator,
  input  logic [gcc_pkg::LEN_W-1:0]  divisor,
  output logic                       busy,
  output logic [FRACTION_BITS-1:0]   quotient
);

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);

  logic [CNT_W-1:0]          count;
  logic [gcc_pkg::LEN_W-1:0] remainder;
  logic [gcc_pkg::LEN_W-1:0] dvs;
  logic [gcc_pkg::LEN_W:0]   shifted;
  logic [gcc_pkg::LEN_W:0]   trial;
  logic                      fits;

  // One restoring step: the remainder stays below the divisor, so the
  // doubled value fits one extra bit and the sign of the trial decides.
  assign shifted = {remainder, 1'b0};
  assign trial   = shifted - {1'b0, dvs};
  assign fits    = !trial[gcc_pkg::LEN_W];
  assign busy    = count != '0;

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(FRACTION_BITS);
    end else if (busy) begin
      count <= count - CNT_W'(1);
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= numerator;
      dvs       <= divisor;
    end else if (busy) begin
      remainder <= fits ? trial[gcc_pkg::LEN_W-1:0] : shifted[gcc_pkg::LEN_W-1:0];
      quotient  <= FRACTION_BITS'({quotient, fits});
    end
  end

  `GCC_ASSERT_IMP(a_div_no_restart, start, !busy, "divider started while busy")
  `GCC_ASSERT_IMP(a_div_steps, busy && !start, ##1 (count == $past(count) - CNT_W'(1)),
                  "divider step count did not decrement")

endmodule

// ===== design/gcc_calendar.sv =====
// ----------------------------------------------------------------------------
// gcc_calendar
// Holds the calendar and applies a load from the start date or a one-minute
// advance with minute, hour, day, month and year rollover.
// ----------------------------------------------------------------------------
module gcc_calendar (
  input  logic                clk,
  input  logic                rst,
  input  gcc_pkg::cal_ctrl_t  ctrl,
  input  logic [13:0]         start_year,
  input  logic [3:0]          start_month,
  input  logic [4:0]          start_day,
  input  logic [4:0]          start_hour,
  input  logic [5:0]          start_minute,
  output gcc_pkg::date_t      date,
  output gcc_pkg::date_t      date_next,
  output gcc_pkg::cal_event_t events
);

  localparam gcc_pkg::date_t DATE_RESET = '{
    minute:      6'd0,
    hour:        5'd0,
    day:         5'd1,
    month:       4'd1,
    year:        14'd2000,
    day_of_year: 9'd1
  };

  gcc_pkg::date_t      date_load;
  gcc_pkg::date_t      date_adv;
  gcc_pkg::cal_event_t adv_events;
  logic [5:0]          minute_inc;
  logic [4:0]          hour_inc;
  logic [4:0]          day_inc;
  logic [3:0]          month_inc;
  logic [14:0]         year_inc;
  logic [8:0]          doy_inc;
  logic                leap_cur;
  logic                leap_start;

  assign leap_cur   = gcc_pkg::is_leap(date.year);
  assign leap_start = gcc_pkg::is_leap(start_year);
  assign minute_inc = date.minute + 6'd1;
  assign hour_inc   = date.hour + 5'd1;
  assign day_inc    = date.day + 5'd1;
  assign month_inc  = date.month + 4'd1;
  assign year_inc   = {1'b0, date.year} + 15'd1;
  assign doy_inc    = date.day_of_year + 9'd1;

  // Start date with its day of year from the cumulative month table.
  always_comb begin
    date_load.minute      = start_minute;
    date_load.hour        = start_hour;
    date_load.day         = start_day;
    date_load.month       = start_month;
    date_load.year        = start_year;
    date_load.day_of_year = gcc_pkg::days_before(start_month, leap_start) + 9'(start_day);
  end

  // One-minute advance; each unit rolls over when it passes its limit.
  always_comb begin
    date_adv   = date;
    adv_events = '0;
    if (minute_inc > gcc_pkg::MINUTE_LAST) begin
      date_adv.minute = '0;
      adv_events.hour = 1'b1;
      if (hour_inc > gcc_pkg::HOUR_LAST) begin
        date_adv.hour        = '0;
        adv_events.day       = 1'b1;
        date_adv.day_of_year = doy_inc;
        if (day_inc > gcc_pkg::month_len(date.month, leap_cur)) begin
          date_adv.day     = 5'd1;
          adv_events.month = 1'b1;
          if (month_inc > gcc_pkg::MONTH_LAST) begin
            date_adv.month       = 4'd1;
            adv_events.year      = 1'b1;
            date_adv.day_of_year = 9'd1;
            date_adv.year        = (year_inc > {1'b0, gcc_pkg::YEAR_LAST}) ?
                                   '0 : year_inc[13:0];
          end else begin
            date_adv.month = month_inc;
          end
        end else begin
          date_adv.day = day_inc;
        end
      end else begin
        date_adv.hour = hour_inc;
      end
    end else begin
      date_adv.minute = minute_inc;
    end
  end

  // Select the update for this cycle.
  always_comb begin
    priority if (ctrl.load) begin
      date_next = date_load;
      events    = '0;
    end else if (ctrl.advance) begin
      date_next = date_adv;
      events    = adv_events;
    end else begin
      date_next = date;
      events    = '0;
    end
  end

  // Calendar register.
  always_ff @(posedge clk) begin
    if (rst) begin
      date <= DATE_RESET;
    end else begin
      date <= date_next;
    end
  end

endmodule

// ===== design/game_calendar_clock_unit.sv =====
// ----------------------------------------------------------------------------
// game_calendar_clock_unit
// Scaled calendar clock with a countdown per game minute and a held time of
// day refreshed every few ticks.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and returns exactly one result
// for each. A start transaction, or a tick whose minute fraction is settled
// without a division, goes from the idle state to the finish state, where its
// result is written to the output register once the output is free. A tick
// that refreshes the time of day while the minute countdown lies strictly
// between zero and the minute length first passes through the divide state,
// where the bit-serial divider forms the minute fraction one quotient bit per
// cycle. A result that is still waiting at the output delays only the
// completion of the following transaction; the next input is accepted as
// soon as the sequencer is back in its idle state. Configuration is written
// through a plain write port and takes effect for the next transaction if
// the user writes it between transactions; the block itself does not
// enforce this.
`include "assert_macros.svh"

module game_calendar_clock_unit #(
  parameter int FRACTION_BITS = gcc_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  gcc_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gcc_pkg::out_item_t                out_data,
  input  logic                              cfg_write_enable,
  input  logic [gcc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gcc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int FRAC_W = FRACTION_BITS + 1;
  localparam int SUM_W  = (gcc_pkg::HM_W + FRAC_W > gcc_pkg::TIME_W) ?
                          gcc_pkg::HM_W + FRAC_W : gcc_pkg::TIME_W;
  localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [gcc_pkg::CD_W-1:0] CD_MAX = {1'b0, {(gcc_pkg::CD_W-1){1'b1}}};
  localparam logic [gcc_pkg::CD_W-1:0] CD_MIN = {1'b1, {(gcc_pkg::CD_W-1){1'b0}}};

  // Saturate a countdown value that has one guard bit.
  function automatic logic [gcc_pkg::CD_W-1:0] sat_cd(input logic [gcc_pkg::CD_W:0] v);
    logic [gcc_pkg::CD_W-1:0] r;
    if (v[gcc_pkg::CD_W] != v[gcc_pkg::CD_W-1]) begin
      r = v[gcc_pkg::CD_W] ? CD_MIN : CD_MAX;
    end else begin
      r = v[gcc_pkg::CD_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [gcc_pkg::LEN_W-1:0]    minute_length;
  logic [gcc_pkg::PERIOD_W-1:0] precise_period;
  logic [13:0]                  start_year;
  logic [3:0]                   start_month;
  logic [4:0]                   start_day;
  logic [4:0]                   start_hour;
  logic [5:0]                   start_minute;

  // Clock state.
  logic [gcc_pkg::CD_W-1:0]     countdown;
  logic [gcc_pkg::PERIOD_W-1:0] tick_count;
  logic [gcc_pkg::TIME_W-1:0]   held_time;
  gcc_pkg::state_t              state;
  gcc_pkg::state_t              state_next;

  // Per-transaction registers.
  logic                         op_reg;
  logic                         refresh_reg;
  logic                         use_div;
  logic [FRAC_W-1:0]            frac_reg;

  // Control and datapath signals.
  logic                         accept;
  logic                         apply;
  logic                         out_free;
  logic                         is_tick;
  logic                         div_start;
  logic                         div_busy;
  logic [FRACTION_BITS-1:0]     div_quotient;
  logic [gcc_pkg::PERIOD_W-1:0] tick_inc;
  logic                         refresh;
  logic                         cd_nonpos;
  logic                         cd_ge_len;
  logic                         len_zero;
  logic                         need_div;
  logic [FRAC_W-1:0]            frac_direct;
  logic [FRAC_W-1:0]            frac_used;
  logic [gcc_pkg::LEN_W-1:0]    div_numerator;
  logic [gcc_pkg::CD_W:0]       cd_diff;
  logic [gcc_pkg::CD_W:0]       cd_refill;
  logic [gcc_pkg::HM_W-1:0]     hour_minutes;
  logic [SUM_W-1:0]             time_sum;
  logic [gcc_pkg::TIME_W-1:0]   held_next;
  gcc_pkg::cal_ctrl_t           cal_ctrl;
  gcc_pkg::date_t               date;
  gcc_pkg::date_t               date_next;
  gcc_pkg::cal_event_t          events;

  // Handshake.
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign is_tick  = in_data.operation == gcc_pkg::OP_TICK;

  // Tick counter toward the refresh period.
  assign tick_inc = tick_count + gcc_pkg::PERIOD_W'(1);
  assign refresh  = tick_inc == precise_period;

  // Minute fraction: the special cases are settled at once, the rest goes
  // through the divider.
  assign len_zero      = minute_length == '0;
  assign cd_nonpos     = countdown[gcc_pkg::CD_W-1] || (countdown == '0);
  assign cd_ge_len     = !countdown[gcc_pkg::CD_W-1] &&
                         (countdown[gcc_pkg::LEN_W-1:0] >= minute_length);
  assign need_div      = !len_zero && !cd_nonpos && !cd_ge_len;
  assign frac_direct   = (!len_zero && cd_nonpos) ? FRAC_ONE : '0;
  assign div_numerator = minute_length - countdown[gcc_pkg::LEN_W-1:0];
  assign frac_used     = use_div ? {1'b0, div_quotient} : frac_reg;

  // Countdown arithmetic with one guard bit.
  assign cd_diff   = {countdown[gcc_pkg::CD_W-1], countdown} -
                     (gcc_pkg::CD_W+1)'(in_data.delta_time_us);
  assign cd_refill = {countdown[gcc_pkg::CD_W-1], countdown} +
                     (gcc_pkg::CD_W+1)'(minute_length);

  // Held time of day from the calendar before this minute's advance.
  assign hour_minutes = gcc_pkg::HM_W'(date.hour) * gcc_pkg::HM_W'(gcc_pkg::MINUTES_PER_HOUR) +
                        gcc_pkg::HM_W'(date.minute);
  assign time_sum     = (SUM_W'(hour_minutes) << FRACTION_BITS) + SUM_W'(frac_used);
  assign held_next    = time_sum[gcc_pkg::TIME_W-1:0];

  // Calendar requests on the completion cycle.
  assign cal_ctrl.load    = apply && (op_reg == gcc_pkg::OP_START);
  assign cal_ctrl.advance = apply && (op_reg == gcc_pkg::OP_TICK) && cd_nonpos;

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      gcc_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (is_tick && refresh && need_div) ? gcc_pkg::ST_DIVIDE :
                                                          gcc_pkg::ST_FINISH;
        end
      end
      gcc_pkg::ST_DIVIDE: begin
        if (!div_busy) begin
          state_next = gcc_pkg::ST_FINISH;
        end
      end
      gcc_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = gcc_pkg::ST_IDLE;
        end
      end
      default: state_next = gcc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = state != gcc_pkg::ST_IDLE;
    apply     = (state == gcc_pkg::ST_FINISH) && out_free;
    div_start = (state == gcc_pkg::ST_IDLE) && accept && is_tick && refresh && need_div;
  end

  // Configuration, clock state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      minute_length  <= gcc_pkg::LEN_W'(2500000);
      precise_period <= gcc_pkg::PERIOD_W'(10);
      start_year     <= 14'd2000;
      start_month    <= 4'd1;
      start_day      <= 5'd1;
      start_hour     <= 5'd0;
      start_minute   <= 6'd0;
      countdown      <= '0;
      tick_count     <= '0;
      held_time      <= '0;
      state          <= gcc_pkg::ST_IDLE;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write_enable) begin
        unique case (gcc_pkg::cfg_reg_t'(cfg_index))
          gcc_pkg::REG_MINUTE_LENGTH:  minute_length  <= cfg_data[gcc_pkg::LEN_W-1:0];
          gcc_pkg::REG_PRECISE_PERIOD: precise_period <= cfg_data[gcc_pkg::PERIOD_W-1:0];
          gcc_pkg::REG_START_YEAR:     start_year     <= cfg_data[13:0];
          gcc_pkg::REG_START_MONTH:    start_month    <= cfg_data[3:0];
          gcc_pkg::REG_START_DAY:      start_day      <= cfg_data[4:0];
          gcc_pkg::REG_START_HOUR:     start_hour     <= cfg_data[4:0];
          gcc_pkg::REG_START_MINUTE:   start_minute   <= cfg_data[5:0];
          default: begin
          end
        endcase
      end

      // Acceptance: a start reloads the countdown, a tick counts and
      // subtracts the elapsed time.
      if (accept) begin
        if (is_tick) begin
          countdown  <= sat_cd(cd_diff);
          tick_count <= refresh ? '0 : tick_inc;
        end else begin
          countdown <= gcc_pkg::CD_W'(minute_length);
        end
      end

      // Completion: refill the countdown when a minute has run out and store the refreshed time of day.
      if (apply) begin
        if (cal_ctrl.advance) begin
          countdown <= sat_cd(cd_refill);
        end
        if (refresh_reg) begin
          held_time <= held_next;
        end
      end

      if (apply) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-transaction payload and output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg      <= in_data.operation;
      refresh_reg <= is_tick && refresh;
      use_div     <= need_div;
      frac_reg    <= frac_direct;
    end
    if (apply) begin
      out_data.minute         <= date_next.minute;
      out_data.hour           <= date_next.hour;
      out_data.day_of_month   <= date_next.day;
      out_data.month          <= date_next.month;
      out_data.year           <= date_next.year;
      out_data.day_of_year    <= date_next.day_of_year;
      out_data.time_of_day    <= refresh_reg ? held_next : held_time;
      out_data.precise_update <= refresh_reg;
      out_data.hour_event     <= events.hour;
      out_data.day_event      <= events.day;
      out_data.month_event    <= events.month;
      out_data.year_event     <= events.year;
    end
  end

  // Minute fraction divider.
  gcc_frac_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_frac_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .numerator (div_numerator),
    .divisor   (minute_length),
    .busy      (div_busy),
    .quotient  (div_quotient)
  );

  // Calendar.
  gcc_calendar u_calendar (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (cal_ctrl),
    .start_year   (start_year),
    .start_month  (start_month),
    .start_day    (start_day),
    .start_hour   (start_hour),
    .start_minute (start_minute),
    .date         (date),
    .date_next    (date_next),
    .events       (events)
  );

  `GCC_ASSERT_IMP(a_div_in_divide, div_busy, state == gcc_pkg::ST_DIVIDE,
                  "divider busy outside the divide state")
  `GCC_ASSERT_IMP(a_event_chain, out_valid && out_data.year_event,
                  out_data.month_event && out_data.day_event && out_data.hour_event,
                  "year rollover without the lower rollovers")
  `GCC_ASSERT_IMP(a_start_quiet, apply && (op_reg == gcc_pkg::OP_START),
                  ##1 (!out_data.precise_update && !out_data.hour_event),
                  "start transaction produced a pulse flag")

endmodule

// ===== verif/tb_game_calendar_clock_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_game_calendar_clock_unit
// Self-checking testbench for the scaled game calendar clock. A calendar
// predictor keeps its own copy of the date, the minute countdown and the
// configuration. It computes the expected result of every accepted
// transaction. Directed transactions cover the calendar corners. Random
// phases then start mostly near rollover boundaries and tick at varied
// paces, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------

// Calendar predictor and result checker.
class calendar_scoreboard;
  localparam int           FRAC_BITS = gcc_pkg::FRACTION_BITS_DEFAULT;
  localparam longint       CD_HIGH   = (longint'(1) << (gcc_pkg::CD_W - 1)) - 1;
  localparam longint       CD_LOW    = -(longint'(1) << (gcc_pkg::CD_W - 1));

  // Configuration copy.
  logic [25:0] minute_len;
  logic [9:0]  refresh_period;
  logic [13:0] load_year;
  logic [3:0]  load_month;
  logic [4:0]  load_day;
  logic [4:0]  load_hour;
  logic [5:0]  load_minute;

  // Calendar state.
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [13:0] year;
  logic [8:0]  yday;
  longint      countdown;
  logic [9:0]  tick_count;
  logic [18:0] held_tod;

  gcc_pkg::out_item_t expected_q[$];
  int unsigned        mismatches;
  int unsigned        results_seen;

  function new();
    minute_len     = 26'd2500000;
    refresh_period = 10'd10;
    load_year      = 14'd2000;
    load_month     = 4'd1;
    load_day       = 5'd1;
    load_hour      = 5'd0;
    load_minute    = 6'd0;
    minute         = 6'd0;
    hour           = 5'd0;
    day            = 5'd1;
    month          = 4'd1;
    year           = 14'd2000;
    yday           = 9'd1;
    countdown      = 0;
    tick_count     = 10'd0;
    held_tod       = 19'd0;
    mismatches     = 0;
    results_seen   = 0;
  endfunction

  function bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Months outside 1..12 count as 31 days.
  function int unsigned days_in(int unsigned m, int unsigned y);
    if (m < 1 || m > 12) return 31;
    if (m == 2) return leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function longint clamp(longint v);
    if (v > CD_HIGH) return CD_HIGH;
    if (v < CD_LOW) return CD_LOW;
    return v;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function void set_register(gcc_pkg::cfg_reg_t idx, logic [25:0] value);
    case (idx)
      gcc_pkg::REG_MINUTE_LENGTH:  minute_len     = value;
      gcc_pkg::REG_PRECISE_PERIOD: refresh_period = value[9:0];
      gcc_pkg::REG_START_YEAR:     load_year      = value[13:0];
      gcc_pkg::REG_START_MONTH:    load_month     = value[3:0];
      gcc_pkg::REG_START_DAY:      load_day       = value[4:0];
      gcc_pkg::REG_START_HOUR:     load_hour      = value[4:0];
      gcc_pkg::REG_START_MINUTE:   load_minute    = value[5:0];
      default: ;
    endcase
  endfunction

  // Works out the result of one accepted transaction and queues it.
  task note_input(gcc_pkg::in_item_t item);
    gcc_pkg::out_item_t want;
    longint             len;
    longint             frac;
    longint unsigned    tod;
    int unsigned        doy;
    int unsigned        next_year;
    want = '0;
    len  = longint'(minute_len);
    if (item.operation == gcc_pkg::OP_START) begin
      year   = load_year;
      month  = load_month;
      day    = load_day;
      hour   = load_hour;
      minute = load_minute;
      doy    = 0;
      for (int unsigned m = 1; m < 32'(month) && m <= 12; m++) begin
        doy += days_in(m, 32'(year));
      end
      yday      = 9'(doy + 32'(day));
      countdown = len;
    end else begin
      // Count toward the refresh period, then refresh the held time of day.
      tick_count = tick_count + 10'd1;
      if (tick_count == refresh_period) begin
        tick_count          = 10'd0;
        want.precise_update = 1'b1;
        if (len == 0) frac = 0;
        else if (countdown <= 0) frac = longint'(1) << FRAC_BITS;
        else if (countdown >= len) frac = 0;
        else frac = ((len - countdown) << FRAC_BITS) / len;
        tod      = ((longint'(hour) * 60 + longint'(minute)) << FRAC_BITS) + frac;
        held_tod = tod[18:0];
      end
      // Spend the elapsed time and advance at most one minute.
      countdown = clamp(countdown - longint'(item.delta_time_us));
      if (countdown <= 0) begin
        countdown = clamp(countdown + len);
        minute    = minute + 6'd1;
        if (minute > gcc_pkg::MINUTE_LAST) begin
          minute          = 6'd0;
          want.hour_event = 1'b1;
          hour            = hour + 5'd1;
          if (hour > gcc_pkg::HOUR_LAST) begin
            hour           = 5'd0;
            want.day_event = 1'b1;
            day            = day + 5'd1;
            yday           = yday + 9'd1;
            if (32'(day) > days_in(32'(month), 32'(year))) begin
              day              = 5'd1;
              want.month_event = 1'b1;
              month            = month + 4'd1;
              if (month > gcc_pkg::MONTH_LAST) begin
                month           = 4'd1;
                want.year_event = 1'b1;
                next_year       = 32'(year) + 32'd1;
                year            = (next_year > 32'(gcc_pkg::YEAR_LAST)) ?
                                  14'd0 : next_year[13:0];
                yday            = 9'd1;
              end
            end
          end
        end
      end
    end
    want.minute       = minute;
    want.hour         = hour;
    want.day_of_month = day;
    want.month        = month;
    want.year         = year;
    want.day_of_year  = yday;
    want.time_of_day  = held_tod;
    expected_q.push_back(want);
  endtask

  task report(string what);
    mismatches++;
    $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  task check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report($sformatf("result %0d %s: got %0d, expected %0d",
                       results_seen, field, got, want));
  endtask

  // Compares one accepted result with the oldest expectation.
  task check_result(gcc_pkg::out_item_t got);
    gcc_pkg::out_item_t want;
    results_seen++;
    if (expected_q.size() == 0) begin
      report($sformatf("result %0d arrived with no transaction waiting", results_seen));
      return;
    end
    want = expected_q.pop_front();
    check_field("minute", 32'(got.minute), 32'(want.minute));
    check_field("hour", 32'(got.hour), 32'(want.hour));
    check_field("day_of_month", 32'(got.day_of_month), 32'(want.day_of_month));
    check_field("month", 32'(got.month), 32'(want.month));
    check_field("year", 32'(got.year), 32'(want.year));
    check_field("day_of_year", 32'(got.day_of_year), 32'(want.day_of_year));
    check_field("time_of_day", 32'(got.time_of_day), 32'(want.time_of_day));
    check_field("precise_update", 32'(got.precise_update), 32'(want.precise_update));
    check_field("hour_event", 32'(got.hour_event), 32'(want.hour_event));
    check_field("day_event", 32'(got.day_event), 32'(want.day_event));
    check_field("month_event", 32'(got.month_event), 32'(want.month_event));
    check_field("year_event", 32'(got.year_event), 32'(want.year_event));
  endtask
endclass

module tb_game_calendar_clock_unit;
  localparam int unsigned ITEM_TARGET = 1550;
  localparam int unsigned IDLE_GUARD  = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DELTA_MAX   = 1000000;

  // How fast the ticks of a random phase eat into the minute countdown.
  typedef enum int unsigned {
    PACE_FAST,
    PACE_FINE,
    PACE_ANY,
    PACE_FLOOR
  } pace_t;

  logic                            clk              = 1'b0;
  logic                            rst              = 1'b1;
  logic                            in_valid         = 1'b0;
  logic                            in_stall;
  gcc_pkg::in_item_t               in_data          = '0;
  logic                            out_valid;
  logic                            out_stall        = 1'b0;
  gcc_pkg::out_item_t              out_data;
  logic                            cfg_write_enable = 1'b0;
  logic [gcc_pkg::CFG_INDEX_W-1:0] cfg_index        = '0;
  logic [gcc_pkg::CFG_DATA_W-1:0]  cfg_data         = '0;

  calendar_scoreboard calendar_sb = new();
  int unsigned        items_sent  = 0;
  int unsigned        cycle_count = 0;
  bit                 in_quiet    = 1'b0;
  bit                 out_quiet   = 1'b0;

  game_calendar_clock_unit dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 32'd1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Check every result transaction taken from the block.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) calendar_sb.check_result(out_data);
  end

  // Waiting cycles per transaction, with quiet stretches that do not wait.
  function automatic int unsigned draw_gap(inout bit quiet);
    if ($urandom_range(0, 49) == 0) quiet = !quiet;
    if (quiet) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 3);
  endfunction

  // Receiver: stall for a drawn number of cycles, then take one result.
  initial begin
    int unsigned gap;
    forever begin
      gap = draw_gap(out_quiet);
      @(negedge clk);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Sends one transaction; valid stays high when the next one follows at once.
  task automatic send_item(input logic operation, input logic [19:0] delta);
    gcc_pkg::in_item_t item;
    int unsigned       gap;
    item.operation     = operation;
    item.delta_time_us = delta;
    gap                = draw_gap(in_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    calendar_sb.note_input(item);
    items_sent++;
  endtask

  // Drops valid and waits until every expected result has come back.
  task automatic wait_until_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (calendar_sb.pending() != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
  endtask

  task automatic write_reg(input gcc_pkg::cfg_reg_t idx, input int unsigned value);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= gcc_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    calendar_sb.set_register(idx, 26'(value));
  endtask

  task automatic end_config();
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  task automatic write_date(input int unsigned y, input int unsigned mo, input int unsigned d,
                            input int unsigned h, input int unsigned mi);
    write_reg(gcc_pkg::REG_START_YEAR, y);
    write_reg(gcc_pkg::REG_START_MONTH, mo);
    write_reg(gcc_pkg::REG_START_DAY, d);
    write_reg(gcc_pkg::REG_START_HOUR, h);
    write_reg(gcc_pkg::REG_START_MINUTE, mi);
  endtask

  function automatic logic [19:0] tick_delta(input pace_t pace, input int unsigned len);
    int unsigned top;
    case (pace)
      PACE_FAST: begin
        if (len <= DELTA_MAX) return 20'($urandom_range(len, DELTA_MAX));
        return 20'($urandom_range(0, DELTA_MAX));
      end
      PACE_FINE: begin
        top = len / 4;
        if (top > DELTA_MAX) top = DELTA_MAX;
        return 20'($urandom_range(0, top));
      end
      PACE_FLOOR: return 20'(DELTA_MAX);
      default: begin
        if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 20'(DELTA_MAX) : 20'd0;
        return 20'($urandom_range(0, DELTA_MAX));
      end
    endcase
  endfunction

  // One random phase: new settings, mostly near a rollover, then a run of ticks.
  task automatic random_phase();
    int unsigned len_pick;
    int unsigned period_pick;
    int unsigned year_pick;
    int unsigned month_pick;
    int unsigned day_pick;
    int unsigned hour_pick;
    int unsigned minute_pick;
    int unsigned tick_total;
    pace_t       pace;
    wait_until_idle();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: len_pick = $urandom_range(1, 3000);
      4:          len_pick = 0;
      5:          len_pick = 'h3FFFFFF;
      6:          len_pick = 60000000;
      7:          len_pick = 1;
      default:    len_pick = $urandom_range(1000, 60000000);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: period_pick = $urandom_range(1, 8);
      6:                period_pick = 0;
      7:                period_pick = 1023;
      8:                period_pick = $urandom_range(0, 1023);
      default:          period_pick = 1;
    endcase
    case ($urandom_range(0, 7))
      0:       year_pick = 9999;
      1:       year_pick = $urandom_range(10000, 16383);
      2:       year_pick = 1900 + 100 * $urandom_range(0, 5);
      3:       year_pick = 4 * $urandom_range(0, 2499);
      default: year_pick = $urandom_range(0, 9999);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: month_pick = 12;
      4, 5:       month_pick = 2;
      6:          month_pick = $urandom_range(0, 15);
      default:    month_pick = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: day_pick = calendar_sb.days_in(month_pick, year_pick);
      5:             day_pick = $urandom_range(0, 31);
      default:       day_pick = $urandom_range(1, 31);
    endcase
    case ($urandom_range(0, 5))
      0, 1, 2: hour_pick = 23;
      3:       hour_pick = $urandom_range(0, 31);
      default: hour_pick = $urandom_range(0, 23);
    endcase
    case ($urandom_range(0, 5))
      0, 1, 2: minute_pick = $urandom_range(50, 59);
      3:       minute_pick = $urandom_range(0, 63);
      default: minute_pick = $urandom_range(0, 59);
    endcase
    write_reg(gcc_pkg::REG_MINUTE_LENGTH, len_pick);
    write_reg(gcc_pkg::REG_PRECISE_PERIOD, period_pick);
    write_date(year_pick, month_pick, day_pick, hour_pick, minute_pick);
    end_config();

    pace       = pace_t'($urandom_range(0, 2));
    tick_total = $urandom_range(5, 40);
    // A zero minute length with full ticks drives the countdown into its floor.
    if (len_pick == 0 && $urandom_range(0, 1) == 1) begin
      pace       = PACE_FLOOR;
      tick_total = 80;
    end
    if ($urandom_range(0, 5) != 0) begin
      send_item(gcc_pkg::OP_START, 20'($urandom_range(0, DELTA_MAX)));
    end
    repeat (tick_total) begin
      if ($urandom_range(0, 24) == 0) begin
        send_item(gcc_pkg::OP_START, 20'($urandom_range(0, DELTA_MAX)));
      end else begin
        send_item(gcc_pkg::OP_TICK, tick_delta(pace, len_pick));
      end
    end
  endtask

  // Main stimulus sequence.
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: a tick with no elapsed time, a full tick, then a start.
    send_item(gcc_pkg::OP_TICK, 20'd0);
    send_item(gcc_pkg::OP_TICK, 20'(DELTA_MAX));
    send_item(gcc_pkg::OP_START, 20'(DELTA_MAX));

    // Last minute of year 9999 rolls every field over at once.
    wait_until_idle();
    write_reg(gcc_pkg::REG_MINUTE_LENGTH, 1);
    write_reg(gcc_pkg::REG_PRECISE_PERIOD, 1);
    write_date(9999, 12, 31, 23, 59);
    end_config();
    send_item(gcc_pkg::OP_START, 20'd0);
    send_item(gcc_pkg::OP_TICK, 20'd1);
    send_item(gcc_pkg::OP_TICK, 20'd0);

    // Leap February in 2000 with a zero minute length and a zero period.
    wait_until_idle();
    write_reg(gcc_pkg::REG_MINUTE_LENGTH, 0);
    write_reg(gcc_pkg::REG_PRECISE_PERIOD, 0);
    write_date(2000, 2, 28, 23, 59);
    end_config();
    send_item(gcc_pkg::OP_START, 20'd0);
    send_item(gcc_pkg::OP_TICK, 20'(DELTA_MAX));

    // 1900 is not a leap year, so February 28 rolls into March.
    wait_until_idle();
    write_reg(gcc_pkg::REG_START_YEAR, 1900);
    end_config();
    send_item(gcc_pkg::OP_START, 20'd0);
    send_item(gcc_pkg::OP_TICK, 20'd0);

    // Oversized start values and the longest minute.
    wait_until_idle();
    write_reg(gcc_pkg::REG_MINUTE_LENGTH, 'h3FFFFFF);
    write_reg(gcc_pkg::REG_PRECISE_PERIOD, 2);
    write_date(16383, 13, 31, 31, 63);
    end_config();
    send_item(gcc_pkg::OP_START, 20'd0);
    send_item(gcc_pkg::OP_TICK, 20'd0);
    send_item(gcc_pkg::OP_TICK, 20'(DELTA_MAX));

    // Month and day of zero.
    wait_until_idle();
    write_reg(gcc_pkg::REG_MINUTE_LENGTH, 1);
    write_date(2023, 0, 0, 23, 59);
    end_config();
    send_item(gcc_pkg::OP_START, 20'd0);
    send_item(gcc_pkg::OP_TICK, 20'd1);

    // Refresh with the countdown partway through a long minute.
    wait_until_idle();
    write_reg(gcc_pkg::REG_MINUTE_LENGTH, 60000000);
    write_reg(gcc_pkg::REG_PRECISE_PERIOD, 1);
    write_date(2024, 15, 31, 12, 30);
    end_config();
    send_item(gcc_pkg::OP_START, 20'd0);
    send_item(gcc_pkg::OP_TICK, 20'd999999);
    send_item(gcc_pkg::OP_TICK, 20'd500000);

    while (items_sent < ITEM_TARGET) random_phase();

    wait_until_idle();
    if (calendar_sb.mismatches == 0 && calendar_sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/gcc_pkg.sv
design/gcc_frac_div.sv
design/gcc_calendar.sv
design/game_calendar_clock_unit.sv
verif/tb_game_calendar_clock_unit.sv
